/* hdl/scgp_pkg.sv */
// Shared types, constants and helpers for the spanning cell grid placer.
// Used by the top level of the block; depends on nothing.
`default_nettype none

package scgp_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 64;
    localparam int ID_BITS     = 16;

    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int CNT_W   = 7;
    localparam int SLOT_AW = ROW_W + COL_W;
    localparam int SLOT_W  = ID_BITS + 1;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_PLACE      = 2'd0,
        OP_SET_LABEL  = 2'd1,
        OP_READ_CELL  = 2'd2,
        OP_READ_LABEL = 2'd3
    } t_op;

    // One row record: occupancy bitmap, used length and label.
    typedef struct packed {
        logic [MAX_COLUMNS-1:0] bitmap;
        logic [CNT_W-1:0]       length;
        logic [ID_BITS-1:0]     label;
    } t_row_rec;

    localparam int ROW_REC_W = $bits(t_row_rec);

    // Bits j up to j+cs-1 of a row bitmap.
    function automatic logic [MAX_COLUMNS-1:0] span_mask(
        input logic [CNT_W-1:0] j,
        input logic [CNT_W-1:0] cs
    );
        logic [MAX_COLUMNS-1:0] m;
        logic [CNT_W:0]         hi;
        hi = {1'b0, j} + {1'b0, cs};
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            m[i] = ((CNT_W+1)'(i) >= {1'b0, j}) && ((CNT_W+1)'(i) < hi);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* hdl/scgp_req_if.sv */
// Request channel of the grid placer: valid/ready and one request item.
// Depends on nothing.
`default_nettype none

interface scgp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [5:0]  row;
    logic [5:0]  column;
    logic [6:0]  row_span;
    logic [6:0]  column_span;
    logic [15:0] cell_id;

    modport source (output valid, op, row, column, row_span, column_span, cell_id,
                    input ready);
    modport sink   (input valid, op, row, column, row_span, column_span, cell_id,
                    output ready);
endinterface

`default_nettype wire

/* hdl/scgp_rsp_if.sv */
// Result channel of the grid placer: valid/ready and one result item.
// Depends on nothing.
`default_nettype none

interface scgp_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  placed_column;
    logic [15:0] found_id;
    logic [6:0]  row_count;
    logic [6:0]  column_count;
    logic        status;

    modport source (output valid, placed_column, found_id, row_count, column_count,
                    status, input ready);
    modport sink   (input valid, placed_column, found_id, row_count, column_count,
                    status, output ready);
endinterface

`default_nettype wire

/* hdl/scgp_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module scgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/spanning_cell_grid_placer_top.sv */
// Reads and label writes register their result in a working state after acceptance;
// a refused span registers it on acceptance. A placement merges the row bitmaps of
// every covered row, scans the columns for a free run, then writes back each covered
// row record and slot. One item is in flight at a time and the next is taken only
// after the result has been taken.
// Reset clears the row valid bits, row count and widest row at once; no sweep.
`default_nettype none

module spanning_cell_grid_placer_top
    import scgp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    scgp_req_if.sink   i_req,
    scgp_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_ACC, S_SCAN, S_RROW, S_UROW, S_OWN, S_LBL, S_RD
    } t_state;

    t_state                 r_state;
    logic [1:0]             r_op;
    logic [ROW_W-1:0]       r_row;
    logic [COL_W-1:0]       r_col;
    logic [CNT_W-1:0]       r_rs;
    logic [CNT_W-1:0]       r_cs;
    logic [ID_BITS-1:0]     r_id;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_pend;
    logic [MAX_COLUMNS-1:0] r_acc;
    logic [CNT_W-1:0]       r_c;
    logic [CNT_W-1:0]       r_run;
    logic [CNT_W-1:0]       r_j;
    logic [CNT_W-1:0]       r_oc;
    logic [MAX_ROWS-1:0]    r_rv;
    logic                   r_rdv;
    logic [CNT_W-1:0]       r_rows;
    logic [CNT_W-1:0]       r_widest;
    logic                   r_out_valid;
    logic [COL_W-1:0]       r_o_col;
    logic [ID_BITS-1:0]     r_o_found;
    logic                   r_o_status;

    logic                 w_accept;
    logic [ROW_W-1:0]     w_row_addr;
    logic [ROW_W-1:0]     w_row_raddr;
    logic                 w_row_we;
    logic [ROW_W-1:0]     w_row_waddr;
    t_row_rec             w_row_wdata;
    logic [ROW_REC_W-1:0] w_row_rdata;
    t_row_rec             w_rec;
    logic                 w_slot_we;
    logic [SLOT_AW-1:0]   w_slot_waddr;
    logic [SLOT_W-1:0]    w_slot_wdata;
    logic [SLOT_W-1:0]    w_slot_rdata;
    logic [CNT_W-1:0]     w_end_col;
    logic [CNT_W-1:0]     w_new_len;
    logic [CNT_W:0]       w_in_top;
    logic [CNT_W:0]       w_top;
    logic                 w_bad_span;

    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;

    // Row record as read; a row never written reads as all zero.
    assign w_rec      = r_rdv ? t_row_rec'(w_row_rdata) : '0;
    assign w_row_addr = r_row + r_cnt[ROW_W-1:0];
    assign w_end_col  = r_j + r_cs;
    assign w_new_len  = (w_rec.length > w_end_col) ? w_rec.length : w_end_col;
    assign w_in_top   = {2'b00, i_req.row} + {1'b0, i_req.row_span};
    assign w_top      = {2'b00, r_row} + {1'b0, r_rs};
    assign w_bad_span = (i_req.row_span == '0) || (i_req.column_span == '0) ||
                        (w_in_top > (CNT_W+1)'(MAX_ROWS));

    // Row RAM port control.
    always_comb begin
        w_row_raddr = (r_state == S_IDLE) ? i_req.row : w_row_addr;
        w_row_we    = (r_state == S_UROW) || (r_state == S_LBL);
        w_row_waddr = (r_state == S_LBL) ? r_row : w_row_addr;
        w_row_wdata = w_rec;
        if (r_state == S_LBL) begin
            w_row_wdata.label = r_id;
        end else begin
            w_row_wdata.length = w_new_len;
            if (r_id != '0) begin
                w_row_wdata.bitmap = w_rec.bitmap | span_mask(r_j, r_cs);
            end
        end
    end

    // Slot RAM writes: the origin slot owns the cell, the rest are spanning.
    assign w_slot_we    = (r_state == S_OWN);
    assign w_slot_waddr = {w_row_addr, r_j[COL_W-1:0] + r_oc[COL_W-1:0]};
    assign w_slot_wdata = {(r_cnt != '0) || (r_oc != '0), r_id};

    scgp_ram #(.WIDTH(ROW_REC_W), .DEPTH(MAX_ROWS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (w_row_waddr),
        .i_wdata (w_row_wdata),
        .i_raddr (w_row_raddr),
        .o_rdata (w_row_rdata)
    );

    scgp_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ROWS*MAX_COLUMNS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_raddr ({i_req.row, i_req.column}),
        .o_rdata (w_slot_rdata)
    );

    // Sequencer: state, row valid bits, counts and the result register.
    always_ff @(posedge i_clk) begin
        r_rdv <= r_rv[w_row_raddr];
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rv        <= '0;
            r_rows      <= '0;
            r_widest    <= '0;
            r_pend      <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_row_we) begin
                r_rv[w_row_waddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op      <= i_req.op;
                        r_row     <= i_req.row;
                        r_col     <= i_req.column;
                        r_rs      <= i_req.row_span;
                        r_cs      <= i_req.column_span;
                        r_id      <= i_req.cell_id;
                        r_cnt     <= '0;
                        r_pend    <= 1'b0;
                        r_acc     <= '0;
                        r_o_found <= '0;
                        r_o_col   <= (t_op'(i_req.op) == OP_PLACE && w_bad_span) ?
                                     '0 : i_req.column;
                        unique case (t_op'(i_req.op))
                            OP_PLACE: begin
                                if (w_bad_span) begin
                                    r_o_status  <= 1'b1;
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_state <= S_ACC;
                                end
                            end
                            OP_SET_LABEL: r_state <= S_LBL;
                            OP_READ_CELL,
                            OP_READ_LABEL: r_state <= S_RD;
                        endcase
                    end
                end
                S_ACC: begin
                    // Merge occupancy of every covered row, one read per cycle.
                    if (r_pend) begin
                        r_acc <= r_acc | w_rec.bitmap;
                    end
                    if (r_cnt != r_rs) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_SCAN;
                            r_c     <= {1'b0, r_col};
                            r_j     <= {1'b0, r_col};
                            r_run   <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    // Walk columns until column_span free ones follow r_j.
                    if (r_run == r_cs) begin
                        r_cnt   <= '0;
                        r_state <= S_RROW;
                    end else if (r_c[CNT_W-1]) begin
                        r_o_col     <= '0;
                        r_o_status  <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (r_acc[r_c[COL_W-1:0]]) begin
                        r_j   <= r_c + 1'b1;
                        r_run <= '0;
                        r_c   <= r_c + 1'b1;
                    end else begin
                        r_run <= r_run + 1'b1;
                        r_c   <= r_c + 1'b1;
                    end
                end
                S_RROW: r_state <= S_UROW;
                S_UROW: begin
                    if (w_new_len > r_widest) begin
                        r_widest <= w_new_len;
                    end
                    r_oc    <= '0;
                    r_state <= S_OWN;
                end
                S_OWN: begin
                    if (r_oc == r_cs - 1'b1) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == r_rs - 1'b1) begin
                            if ({1'b0, r_rows} < w_top) begin
                                r_rows <= w_top[CNT_W-1:0];
                            end
                            r_o_col     <= r_j[COL_W-1:0];
                            r_o_status  <= 1'b0;
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_RROW;
                        end
                    end else begin
                        r_oc <= r_oc + 1'b1;
                    end
                end
                S_LBL: begin
                    if ({1'b0, r_rows} <= {2'b00, r_row}) begin
                        r_rows <= {1'b0, r_row} + 1'b1;
                    end
                    r_o_status  <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_RD: begin
                    if ({1'b0, r_row} < r_rows) begin
                        if (t_op'(r_op) == OP_READ_LABEL) begin
                            r_o_found <= w_rec.label;
                        end else if ({1'b0, r_col} < w_rec.length &&
                                     w_rec.bitmap[r_col]) begin
                            r_o_found <= w_slot_rdata[ID_BITS-1:0];
                        end
                    end
                    r_o_status  <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.placed_column = r_o_col;
    assign o_rsp.found_id      = r_o_found;
    assign o_rsp.row_count     = r_rows;
    assign o_rsp.column_count  = r_widest;
    assign o_rsp.status        = r_o_status;

endmodule

`default_nettype wire

/* hdl/scgp_checker.sv */
// Port-level checks for the grid placer, bound to the top level.
// Depends on the top level's port names only.
`default_nettype none

module scgp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_valid,
    input wire logic       i_req_ready,
    input wire logic       i_rsp_valid,
    input wire logic       i_rsp_ready,
    input wire logic [5:0] i_rsp_placed_column,
    input wire logic [6:0] i_rsp_row_count,
    input wire logic [6:0] i_rsp_column_count,
    input wire logic       i_rsp_status
);

    // A result held back keeps its column.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_placed_column))
        else $error("held result changed");

    // A refused placement reports column zero.
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status |-> i_rsp_placed_column == 6'd0)
        else $error("refusal with nonzero column");

    // Only one item is worked on at a time.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second item taken while busy");

    // The row count and widest row never shrink outside reset.
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> i_rsp_row_count >= $past(i_rsp_row_count) &&
                           i_rsp_column_count >= $past(i_rsp_column_count))
        else $error("counts decreased");

endmodule

bind spanning_cell_grid_placer_top scgp_checker u_scgp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_placed_column (o_rsp.placed_column),
    .i_rsp_row_count     (o_rsp.row_count),
    .i_rsp_column_count  (o_rsp.column_count),
    .i_rsp_status        (o_rsp.status)
);

`default_nettype wire
